/* rtl/otsr_pkg.sv */
`timescale 1ns / 1ps

package otsr_pkg;

	// Table sizes used as defaults on the top level.
	localparam int MAX_SEGMENTS_DEF = 32;
	localparam int MAX_SYMBOLS_DEF = 4096;

	// Fixed field widths.
	localparam int ADDR_W = 64;
	localparam int IDX_W = 12;
	localparam int CMD_W = 2;
	localparam int STAT_W = 2;

	// Commands carried on the input tuser.
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_ADD_SEG = 2'd1,
		CMD_ADD_SYM = 2'd2,
		CMD_LOOKUP  = 2'd3
	} cmd_t;

	// Result status carried on the output tuser.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_NO_SEG = 2'd1,
		STAT_NO_SYM = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	// Operations of the shared adder.
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

/* rtl/otsr_ram.sv */
`timescale 1ns / 1ps

module otsr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/otsr_alu.sv */
`timescale 1ns / 1ps

module otsr_alu
	import otsr_pkg::*;
(
	input  alu_op_t           op,
	input  logic [ADDR_W-1:0] a,
	input  logic [ADDR_W-1:0] b,
	output logic [ADDR_W-1:0] result,
	output logic              borrow
);

	logic [ADDR_W-1:0] b_eff;
	logic [ADDR_W:0]   sum;

	// A subtract is an add of the inverted operand with a carry in.
	assign b_eff = (op == ALU_SUB) ? ~b : b;
	assign sum = {1'b0, a} + {1'b0, b_eff} + {{ADDR_W{1'b0}}, (op == ALU_SUB)};
	assign result = sum[ADDR_W-1:0];

	// Borrow is set when a is below b.
	assign borrow = (op == ALU_SUB) && !sum[ADDR_W];

endmodule

/* rtl/offset_to_symbol_resolver.sv */
`timescale 1ns / 1ps
// Clear and load commands go from the input handshake straight to ST_DONE,
// which loads the output register once it is free. A lookup reads each segment
// in turn and checks its offset and length, then binary-searches the symbols.
// The shared 64-bit adder and the single read port of each table serialise these steps.
// One item at a time; the next is taken in the cycle after a result is loaded.
// arst_n clears both table counts, the sequencer and the output valid.

module offset_to_symbol_resolver
	import otsr_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// lookup_offset, seg_file_offset, seg_virtual_base, seg_file_length,
	// sym_start_address, sym_extent (64 bits each, lowest first)
	input  logic [383:0] s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// virtual_address [63:0], symbol_index [75:64], zero fill above
	output logic [79:0]  m_tdata,
	// status
	output logic [1:0]   m_tuser
);

	localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SYM_AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int SYM_CW = $clog2(MAX_SYMBOLS + 1);
	localparam int SEG_DW = 3 * ADDR_W;
	localparam int SYM_DW = 2 * ADDR_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEG_RD,
		ST_SEG_OFF,
		ST_SEG_LEN,
		ST_SEG_XLT,
		ST_SYM_RD,
		ST_SYM_CMP,
		ST_FIN_RD,
		ST_FIN_SUB,
		ST_FIN_CMP,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [SEG_CW-1:0] seg_count_q;
	logic [SYM_CW-1:0] sym_count_q;
	logic [SEG_CW-1:0] seg_idx_q;
	logic [SYM_CW-1:0] lo_q;
	logic [SYM_CW-1:0] hi_p1_q;
	logic [SYM_AW-1:0] mid_q;
	logic [SYM_AW-1:0] best_q;
	logic              best_vld_q;
	logic [ADDR_W-1:0] off_q;
	logic [ADDR_W-1:0] diff_q;
	logic [ADDR_W-1:0] va_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_va_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              m_tvalid_q;
	status_t           m_status_q;
	logic [ADDR_W-1:0] m_va_q;
	logic [IDX_W-1:0]  m_idx_q;

	logic              in_acc;
	cmd_t              in_cmd;
	logic              seg_full;
	logic              sym_full;
	logic              out_free;
	logic              seg_we;
	logic              sym_we;
	logic              seg_re;
	logic              sym_re;
	logic [SYM_AW-1:0] sym_raddr;
	logic [SEG_DW-1:0] seg_rdata;
	logic [SYM_DW-1:0] sym_rdata;
	logic [ADDR_W-1:0] seg_off;
	logic [ADDR_W-1:0] seg_base;
	logic [ADDR_W-1:0] seg_len;
	logic [ADDR_W-1:0] sym_start;
	logic [ADDR_W-1:0] sym_size;
	logic [SYM_CW:0]   mid_sum;
	logic [SYM_AW-1:0] mid;
	logic              search_on;
	logic [SEG_CW-1:0] seg_next;
	alu_op_t           alu_op;
	logic [ADDR_W-1:0] alu_a;
	logic [ADDR_W-1:0] alu_b;
	logic [ADDR_W-1:0] alu_res;
	logic              alu_borrow;

	// Handshake and table status.
	assign in_acc = s_tvalid && s_tready;
	assign in_cmd = cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign seg_full = (seg_count_q == SEG_CW'(MAX_SEGMENTS));
	assign sym_full = (sym_count_q == SYM_CW'(MAX_SYMBOLS));
	assign out_free = !m_tvalid_q || m_tready;
	assign seg_next = seg_idx_q + SEG_CW'(1);

	// Table loads write at the current fill count.
	assign seg_we = in_acc && (in_cmd == CMD_ADD_SEG) && !seg_full;
	assign sym_we = in_acc && (in_cmd == CMD_ADD_SYM) && !sym_full;

	// Midpoint of the inclusive range [lo, hi_p1 - 1].
	assign search_on = (lo_q < hi_p1_q);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_p1_q} - (SYM_CW + 1)'(1);
	assign mid = mid_sum[SYM_AW:1];

	// Read requests for both tables.
	assign seg_re = (state_q == ST_SEG_RD);
	assign sym_re = ((state_q == ST_SYM_RD) && search_on) || (state_q == ST_FIN_RD);
	assign sym_raddr = (state_q == ST_FIN_RD) ? best_q : mid;

	otsr_ram #(
		.WIDTH(SEG_DW),
		.DEPTH(MAX_SEGMENTS)
	) u_seg_ram (
		.clk  (clk),
		.we   (seg_we),
		.waddr(seg_count_q[SEG_AW-1:0]),
		.wdata(s_tdata[4*ADDR_W-1:ADDR_W]),
		.re   (seg_re),
		.raddr(seg_idx_q[SEG_AW-1:0]),
		.rdata(seg_rdata)
	);

	otsr_ram #(
		.WIDTH(SYM_DW),
		.DEPTH(MAX_SYMBOLS)
	) u_sym_ram (
		.clk  (clk),
		.we   (sym_we),
		.waddr(sym_count_q[SYM_AW-1:0]),
		.wdata(s_tdata[6*ADDR_W-1:4*ADDR_W]),
		.re   (sym_re),
		.raddr(sym_raddr),
		.rdata(sym_rdata)
	);

	assign seg_off = seg_rdata[ADDR_W-1:0];
	assign seg_base = seg_rdata[2*ADDR_W-1:ADDR_W];
	assign seg_len = seg_rdata[3*ADDR_W-1:2*ADDR_W];
	assign sym_start = sym_rdata[ADDR_W-1:0];
	assign sym_size = sym_rdata[2*ADDR_W-1:ADDR_W];

	// Operand selection for the shared adder.
	always_comb begin
		alu_op = ALU_SUB;
		alu_a = off_q;
		alu_b = seg_off;
		case (state_q)
			ST_SEG_LEN: begin
				alu_a = diff_q;
				alu_b = seg_len;
			end
			ST_SEG_XLT: begin
				alu_op = ALU_ADD;
				alu_a = seg_base;
				alu_b = diff_q;
			end
			ST_SYM_CMP, ST_FIN_SUB: begin
				alu_a = va_q;
				alu_b = sym_start;
			end
			ST_FIN_CMP: begin
				alu_a = diff_q;
				alu_b = sym_size;
			end
			default: begin
				alu_a = off_q;
				alu_b = seg_off;
			end
		endcase
	end

	otsr_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.result(alu_res),
		.borrow(alu_borrow)
	);

	// Sequencer, table counts and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_count_q <= '0;
			sym_count_q <= '0;
			seg_idx_q <= '0;
			lo_q <= '0;
			hi_p1_q <= '0;
			mid_q <= '0;
			best_q <= '0;
			best_vld_q <= 1'b0;
			off_q <= '0;
			diff_q <= '0;
			va_q <= '0;
			res_status_q <= STAT_OK;
			res_va_q <= '0;
			res_idx_q <= '0;
			m_tvalid_q <= 1'b0;
			m_status_q <= STAT_OK;
			m_va_q <= '0;
			m_idx_q <= '0;
		end else begin
			// The output register empties when its item is taken and nothing replaces it.
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_va_q <= '0;
						res_idx_q <= '0;
						off_q <= s_tdata[ADDR_W-1:0];
						seg_idx_q <= '0;
						case (in_cmd)
							CMD_CLEAR: begin
								seg_count_q <= '0;
								sym_count_q <= '0;
								res_status_q <= STAT_OK;
								state_q <= ST_DONE;
							end
							CMD_ADD_SEG: begin
								state_q <= ST_DONE;
								if (seg_full) begin
									res_status_q <= STAT_FULL;
								end else begin
									res_status_q <= STAT_OK;
									seg_count_q <= seg_count_q + SEG_CW'(1);
								end
							end
							CMD_ADD_SYM: begin
								state_q <= ST_DONE;
								if (sym_full) begin
									res_status_q <= STAT_FULL;
								end else begin
									res_status_q <= STAT_OK;
									sym_count_q <= sym_count_q + SYM_CW'(1);
								end
							end
							default: begin
								if (seg_count_q == '0) begin
									res_status_q <= STAT_NO_SEG;
									state_q <= ST_DONE;
								end else begin
									res_status_q <= STAT_OK;
									state_q <= ST_SEG_RD;
								end
							end
						endcase
					end
				end
				ST_SEG_RD: begin
					state_q <= ST_SEG_OFF;
				end
				ST_SEG_OFF: begin
					// Offset below the segment start: try the next segment.
					diff_q <= alu_res;
					if (alu_borrow) begin
						seg_idx_q <= seg_next;
						if (seg_next == seg_count_q) begin
							res_status_q <= STAT_NO_SEG;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SEG_RD;
						end
					end else begin
						state_q <= ST_SEG_LEN;
					end
				end
				ST_SEG_LEN: begin
					// Distance into the segment must be below its length.
					if (alu_borrow) begin
						state_q <= ST_SEG_XLT;
					end else begin
						seg_idx_q <= seg_next;
						if (seg_next == seg_count_q) begin
							res_status_q <= STAT_NO_SEG;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SEG_RD;
						end
					end
				end
				ST_SEG_XLT: begin
					// Translated address, then start the search over all symbols.
					va_q <= alu_res;
					res_va_q <= alu_res;
					lo_q <= '0;
					hi_p1_q <= sym_count_q;
					best_vld_q <= 1'b0;
					state_q <= ST_SYM_RD;
				end
				ST_SYM_RD: begin
					if (search_on) begin
						mid_q <= mid;
						state_q <= ST_SYM_CMP;
					end else if (best_vld_q) begin
						state_q <= ST_FIN_RD;
					end else begin
						res_status_q <= STAT_NO_SYM;
						state_q <= ST_DONE;
					end
				end
				ST_SYM_CMP: begin
					// Start at or below the address moves the low bound up.
					if (!alu_borrow) begin
						best_q <= mid_q;
						best_vld_q <= 1'b1;
						lo_q <= SYM_CW'(mid_q) + SYM_CW'(1);
					end else begin
						hi_p1_q <= SYM_CW'(mid_q);
					end
					state_q <= ST_SYM_RD;
				end
				ST_FIN_RD: begin
					state_q <= ST_FIN_SUB;
				end
				ST_FIN_SUB: begin
					diff_q <= alu_res;
					state_q <= ST_FIN_CMP;
				end
				ST_FIN_CMP: begin
					// An open-ended symbol or an address inside the extent is a hit.
					if ((sym_size == '0) || alu_borrow) begin
						res_status_q <= STAT_OK;
						res_idx_q <= IDX_W'(best_q);
					end else begin
						res_status_q <= STAT_NO_SYM;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_va_q <= res_va_q;
						m_idx_q <= res_idx_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output channel.
	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_status_q;
	assign m_tdata = {4'b0000, m_idx_q, m_va_q};

	// The fill counts never pass the table sizes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(seg_count_q <= SEG_CW'(MAX_SEGMENTS)) && (sym_count_q <= SYM_CW'(MAX_SYMBOLS)))
		else $error("table count beyond table size");

	// A clear command empties both tables in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_cmd == CMD_CLEAR)) |=> ((seg_count_q == '0) && (sym_count_q == '0)))
		else $error("clear did not empty the tables");

	// A probe is only taken from a non-empty search range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYM_CMP) |-> ((lo_q < hi_p1_q) && (hi_p1_q <= sym_count_q)))
		else $error("search probe outside the loaded symbols");

	// The segment scan stays below the segment count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEG_RD) |-> (seg_idx_q < seg_count_q))
		else $error("segment scan beyond the loaded segments");

endmodule
